### hdl/lsps_pkg.sv
package lsps_pkg;

	localparam int SENSOR_COUNT = 7;
	localparam int CENTRE       = (SENSOR_COUNT - 1) / 2;
	localparam int WEIGHT_STEP  = 1000;

	localparam int CNT_W     = $clog2(SENSOR_COUNT + 1);
	localparam int SSUM_W    = $clog2(CENTRE * SENSOR_COUNT + 1) + 1;
	localparam int AW        = $clog2(WEIGHT_STEP * CENTRE * SENSOR_COUNT + 1);
	localparam int DIV_CNT_W = $clog2(AW);

	localparam int GAIN_W    = 8;
	localparam int SETP_W    = 13;
	localparam int ERR_W     = 14;
	localparam int DELTA_W   = ERR_W + 1;
	localparam int CORR_W    = 24;
	localparam int MAC_CNT_W = $clog2(GAIN_W);
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam int ERR_MAX = 8191;
	localparam int ERR_MIN = -8192;

	localparam logic [GAIN_W-1:0]        PROP_GAIN_RST  = GAIN_W'(5);
	localparam logic [GAIN_W-1:0]        DERIV_GAIN_RST = GAIN_W'(40);
	localparam logic signed [SETP_W-1:0] SETPOINT_RST   = '0;
	localparam logic                     INVERT_RST     = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_NONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_SIDES    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_CENTERED = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 2'd0,
		REG_DERIV_GAIN = 2'd1,
		REG_SETPOINT   = 2'd2,
		REG_INVERT     = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0]        prop_gain;
		logic [GAIN_W-1:0]        deriv_gain;
		logic signed [SETP_W-1:0] setpoint;
		logic                     invert;
	} cfg_t;

endpackage

### hdl/lsps_cfg_regs.sv
module lsps_cfg_regs import lsps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SETP_W-1:0]    cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain  <= PROP_GAIN_RST;
			cfg_q.deriv_gain <= DERIV_GAIN_RST;
			cfg_q.setpoint   <= SETPOINT_RST;
			cfg_q.invert     <= INVERT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_data[GAIN_W-1:0];
				REG_SETPOINT:   cfg_q.setpoint   <= $signed(cfg_data);
				REG_INVERT:     cfg_q.invert     <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

### hdl/lsps_div.sv
module lsps_div import lsps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [AW-1:0]    quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [AW-1:0]        dvd_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     dsr_q;

	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             fits;
	logic [CNT_W-1:0] rem_next;

	// restoring divide, one quotient bit per cycle; quotient shifts in behind the dividend
	always_comb begin
		trial    = {rem_q, dvd_q[AW-1]};
		diff     = trial - {1'b0, dsr_q};
		fits     = trial >= {1'b0, dsr_q};
		rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_W'(AW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[AW-2:0], fits};
			rem_q <= rem_next;
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

### hdl/lsps_mac.sv
module lsps_mac import lsps_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [ERR_W-1:0]   err,
	input  logic signed [DELTA_W-1:0] delta,
	input  logic [GAIN_W-1:0]         prop_gain,
	input  logic [GAIN_W-1:0]         deriv_gain,
	output logic                      done,
	output logic signed [CORR_W-1:0]  product
);

	logic                     busy_q;
	logic                     done_q;
	logic [MAC_CNT_W-1:0]     cnt_q;
	logic signed [CORR_W-1:0] mp_q;
	logic signed [CORR_W-1:0] md_q;
	logic [GAIN_W-1:0]        pg_q;
	logic [GAIN_W-1:0]        dg_q;
	logic signed [CORR_W-1:0] acc_q;

	logic signed [CORR_W-1:0] add_p;
	logic signed [CORR_W-1:0] add_d;

	// one bit of each gain per cycle, LSB first
	assign add_p = pg_q[0] ? mp_q : '0;
	assign add_d = dg_q[0] ? md_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == MAC_CNT_W'(GAIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mp_q  <= CORR_W'(err);
			md_q  <= CORR_W'(delta);
			pg_q  <= prop_gain;
			dg_q  <= deriv_gain;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + add_p + add_d;
			mp_q  <= mp_q <<< 1;
			md_q  <= md_q <<< 1;
			pg_q  <= pg_q >> 1;
			dg_q  <= dg_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

### hdl/line_sensor_pd_steering_unit.sv
// Line-follower steering: weighted line position from the sensor row, then a PD law.
// Input channel: raw_sensors with in_valid/in_stall; a word is taken when in_valid
// is high and in_stall low. Output channel: correction, no_line, all_clear and
// line_status with out_valid/out_stall; one result word per input word.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while the block is idle. Index 0 prop gain, 1 deriv gain,
// 2 setpoint, 3 sensor invert.
// From accept, a word runs through the bit-serial position divide (one quotient
// bit a cycle) and the shift-add gain multiply (one gain bit a cycle); the
// divide is skipped when no sensor is set.
// One word is in work at a time: in_stall is high from accept until the result
// is loaded into the output register, so no new word is taken before that.
// A stalled receiver holds the result in the output register; the next word is
// still accepted and finishes, then waits until the register frees.
// Reset restores the register defaults and clears the stored last error.
module line_sensor_pd_steering_unit import lsps_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [SENSOR_COUNT-1:0]  raw_sensors,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [CORR_W-1:0] correction,
	output logic                     no_line,
	output logic                     all_clear,
	output logic [STATUS_W-1:0]      line_status,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [SETP_W-1:0]        cfg_data
);

	localparam int POS_W     = AW + 1;
	localparam int ERR_RAW_W = ((POS_W > SETP_W) ? POS_W : SETP_W) + 1;
	localparam logic signed [ERR_RAW_W-1:0] ERR_HI = ERR_RAW_W'(ERR_MAX);
	localparam logic signed [ERR_RAW_W-1:0] ERR_LO = ERR_RAW_W'(ERR_MIN);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DIVIDE = 5'b00010,
		S_ERROR  = 5'b00100,
		S_MULT   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	cfg_t   cfg;
	state_t state_q;

	logic accept;
	logic div_start;
	logic div_done;
	logic [AW-1:0] quotient;
	logic mac_start;
	logic mac_done;
	logic signed [CORR_W-1:0] product;

	// front end
	logic [SENSOR_COUNT-1:0] bits;
	logic signed [SSUM_W-1:0] ssum;
	logic [CNT_W-1:0] cnt;
	logic centre_white;
	logic side_white;
	logic [SSUM_W-1:0] ssum_mag;
	logic [AW-1:0] wabs;
	logic [STATUS_W-1:0] status;

	logic neg_q;
	logic nl_q;
	logic ac_q;
	logic [STATUS_W-1:0] st_q;
	logic signed [ERR_W-1:0] last_error_q;

	logic signed [POS_W-1:0] pos;
	logic signed [ERR_RAW_W-1:0] err_raw;
	logic signed [ERR_W-1:0] err;
	logic signed [DELTA_W-1:0] delta;

	logic out_valid_q;
	logic signed [CORR_W-1:0] correction_q;
	logic no_line_q;
	logic all_clear_q;
	logic [STATUS_W-1:0] status_q;
	logic out_load;

	lsps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		bits         = raw_sensors ^ {SENSOR_COUNT{cfg.invert}};
		ssum         = '0;
		cnt          = '0;
		centre_white = 1'b0;
		side_white   = 1'b0;
		for (int k = 0; k < SENSOR_COUNT; k++) begin
			if (bits[k]) begin
				ssum = ssum + SSUM_W'(k - CENTRE);
				cnt  = cnt + 1'b1;
			end else if (k >= CENTRE - 1 && k <= CENTRE + 1) begin
				centre_white = 1'b1;
			end else begin
				side_white = 1'b1;
			end
		end
		ssum_mag = ssum[SSUM_W-1] ? SSUM_W'(-ssum) : SSUM_W'(ssum);
		wabs     = AW'(32'(ssum_mag) * WEIGHT_STEP);
		if (centre_white && !side_white) begin
			status = STATUS_CENTERED;
		end else if (side_white) begin
			status = STATUS_SIDES;
		end else begin
			status = STATUS_NONE;
		end
	end

	assign div_start = accept && (cnt != '0);

	lsps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (wabs),
		.divisor  (cnt),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= ssum[SSUM_W-1];
			nl_q  <= (cnt == '0);
			ac_q  <= (bits == '0);
			st_q  <= status;
		end
	end

	// truncation toward zero: divide the magnitude, then restore the sign
	always_comb begin
		pos     = neg_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
		err_raw = ERR_RAW_W'(pos) - ERR_RAW_W'(cfg.setpoint);
		if (nl_q) begin
			err = last_error_q;
		end else if (err_raw > ERR_HI) begin
			err = ERR_HI[ERR_W-1:0];
		end else if (err_raw < ERR_LO) begin
			err = ERR_LO[ERR_W-1:0];
		end else begin
			err = err_raw[ERR_W-1:0];
		end
		delta = DELTA_W'(err) - DELTA_W'(last_error_q);
	end

	assign mac_start = (state_q == S_ERROR);

	lsps_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (mac_start),
		.err        (err),
		.delta      (delta),
		.prop_gain  (cfg.prop_gain),
		.deriv_gain (cfg.deriv_gain),
		.done       (mac_done),
		.product    (product)
	);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			last_error_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (cnt == '0) ? S_ERROR : S_DIVIDE;
					end
				end
				S_DIVIDE: begin
					if (div_done) begin
						state_q <= S_ERROR;
					end
				end
				S_ERROR: begin
					last_error_q <= err;
					state_q      <= S_MULT;
				end
				S_MULT: begin
					if (mac_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			correction_q <= product;
			no_line_q    <= nl_q;
			all_clear_q  <= ac_q;
			status_q     <= st_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign correction  = correction_q;
	assign no_line     = no_line_q;
	assign all_clear   = all_clear_q;
	assign line_status = status_q;

endmodule

### tb/testbench.sv
module testbench import lsps_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 500000;
	localparam int REPORT_CAP  = 200;

	typedef struct {
		logic signed [CORR_W-1:0] correction;
		logic                     no_line;
		logic                     all_clear;
		logic [STATUS_W-1:0]      status;
	} steer_word_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [SENSOR_COUNT-1:0]  raw_sensors;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [CORR_W-1:0] correction;
	logic                     no_line;
	logic                     all_clear;
	logic [STATUS_W-1:0]      line_status;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [SETP_W-1:0]        cfg_data;

	// predictor state: register shadow and the stored error
	cfg_t                     steer_cfg;
	logic signed [ERR_W-1:0]  held_error;
	steer_word_t              pending_steer[$];
	steer_word_t              oldest_steer;

	int  fail_count;
	int  cycle_count;
	int  stall_left;
	bit  idle_on;
	bit  stall_long;

	line_sensor_pd_steering_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.raw_sensors (raw_sensors),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.correction  (correction),
		.no_line     (no_line),
		.all_clear   (all_clear),
		.line_status (line_status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic report(input string msg);
		if (fail_count < REPORT_CAP)
			$display("%0t ns: %s", $time, msg);
		fail_count++;
	endtask

	function automatic steer_word_t predict_steering(input logic [SENSOR_COUNT-1:0] raw);
		steer_word_t             w;
		logic [SENSOR_COUNT-1:0] bits;
		int                      wsum;
		int                      hits;
		int                      err;
		int                      corr;
		int                      mid_white;
		int                      side_white;
		int                      k;
		bits = steer_cfg.invert ? ~raw : raw;
		wsum = 0;
		hits = 0;
		mid_white = 0;
		side_white = 0;
		for (k = 0; k < SENSOR_COUNT; k++) begin
			if (bits[k]) begin
				wsum += (k - CENTRE) * WEIGHT_STEP;
				hits++;
			end else if (k >= CENTRE - 1 && k <= CENTRE + 1) begin
				mid_white++;
			end else begin
				side_white++;
			end
		end
		// no line: error holds, so the derivative term vanishes
		if (hits == 0) begin
			err = held_error;
		end else begin
			err = wsum / hits - int'($signed(steer_cfg.setpoint));
			if (err > ERR_MAX)
				err = ERR_MAX;
			if (err < ERR_MIN)
				err = ERR_MIN;
		end
		corr = int'(steer_cfg.prop_gain) * err + int'(steer_cfg.deriv_gain) * (err - held_error);
		held_error = ERR_W'(err);
		w.correction = corr[CORR_W-1:0];
		w.no_line = (hits == 0);
		w.all_clear = (bits == '0);
		if (mid_white >= 1 && side_white == 0)
			w.status = STATUS_CENTERED;
		else if (side_white > 0)
			w.status = STATUS_SIDES;
		else
			w.status = STATUS_NONE;
		return w;
	endfunction

	// random stall bursts and the long hold-off on the result side
	always @(posedge clk) begin
		if (stall_left > 0)
			stall_left = stall_left - 1;
		else if (idle_on && $urandom_range(0, 4) == 0)
			stall_left = $urandom_range(1, 9);
		out_stall <= stall_long || (stall_left > 0);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_steer.size() == 0) begin
				report("result word with nothing expected");
			end else begin
				oldest_steer = pending_steer.pop_front();
				if (correction !== oldest_steer.correction)
					report($sformatf("correction: expected %0d, got %0d",
						oldest_steer.correction, correction));
				if (no_line !== oldest_steer.no_line)
					report($sformatf("no_line: expected %b, got %b",
						oldest_steer.no_line, no_line));
				if (all_clear !== oldest_steer.all_clear)
					report($sformatf("all_clear: expected %b, got %b",
						oldest_steer.all_clear, all_clear));
				if (line_status !== oldest_steer.status)
					report($sformatf("line_status: expected %0d, got %0d",
						oldest_steer.status, line_status));
			end
		end
	end

	task automatic send_word(input logic [SENSOR_COUNT-1:0] raw);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_sensors <= raw;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_steer.push_back(predict_steering(raw));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_steer.size() != 0)
			@(posedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [SETP_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_PROP_GAIN:  steer_cfg.prop_gain = data[GAIN_W-1:0];
			REG_DERIV_GAIN: steer_cfg.deriv_gain = data[GAIN_W-1:0];
			REG_SETPOINT:   steer_cfg.setpoint = data;
			REG_INVERT:     steer_cfg.invert = data[0];
			default: ;
		endcase
	endtask

	// only called with nothing in flight; unused data bits carry noise
	task automatic set_config(input logic [GAIN_W-1:0] pg, input logic [GAIN_W-1:0] dg,
			input logic signed [SETP_W-1:0] sp, input logic inv);
		drain_results();
		put_reg(REG_PROP_GAIN, {(SETP_W - GAIN_W)'($urandom), pg});
		put_reg(REG_DERIV_GAIN, {(SETP_W - GAIN_W)'($urandom), dg});
		put_reg(REG_SETPOINT, sp);
		put_reg(REG_INVERT, {(SETP_W - 1)'($urandom), inv});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SENSOR_COUNT-1:0] pick_sensors();
		logic [SENSOR_COUNT-1:0] one_hot;
		one_hot = SENSOR_COUNT'(1) << $urandom_range(0, SENSOR_COUNT - 1);
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return one_hot;
			3:       return ~one_hot;
			default: return SENSOR_COUNT'($urandom);
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_word(7'h7F);
		send_word(7'h00);
		send_word(7'h77);
		send_word(7'h7E);
	endtask

	task automatic test_directed_cases();
		set_config(8'd255, 8'd255, -13'sd3000, 1'b0);
		send_word(7'h40);
		send_word(7'h00);
		send_word(7'h0B);   // sum -5000 over three: truncates toward zero
		send_word(7'h68);
		send_word(7'h1C);
		send_word(7'h63);
		send_word(7'h7F);
		set_config(8'd0, 8'd0, 13'sd3000, 1'b0);
		send_word(7'h01);
		send_word(7'h7F);
		set_config(8'd255, 8'd255, 13'sd3000, 1'b0);
		send_word(7'h01);
		// full swing of error: largest and smallest correction
		set_config(8'd255, 8'd255, -13'sd3000, 1'b0);
		send_word(7'h40);
		set_config(8'd255, 8'd255, 13'sd3000, 1'b0);
		send_word(7'h01);
		send_word(7'h00);
		set_config(8'd0, 8'd255, 13'sd0, 1'b1);
		send_word(7'h7F);
		send_word(7'h5A);
		send_word(7'h00);
	endtask

	task automatic test_random_settings();
		int                       p;
		int                       i;
		logic [GAIN_W-1:0]        pg;
		logic [GAIN_W-1:0]        dg;
		logic signed [SETP_W-1:0] sp;
		logic                     inv;
		for (p = 0; p < 8; p++) begin
			pg = GAIN_W'($urandom);
			dg = GAIN_W'($urandom);
			sp = SETP_W'(int'($urandom_range(0, 6000)) - 3000);
			inv = 1'($urandom);
			if (p == 0) begin
				pg = '0;
				dg = '0;
			end
			if (p == 1) begin
				pg = '1;
				dg = '1;
				sp = -13'sd3000;
			end
			if (p == 2) begin
				pg = '1;
				dg = '1;
				sp = 13'sd3000;
			end
			set_config(pg, dg, sp, inv);
			for (i = 0; i < 110; i++)
				send_word(pick_sensors());
		end
	endtask

	task automatic test_output_backpressure();
		int i;
		set_config(GAIN_W'($urandom), GAIN_W'($urandom),
			SETP_W'(int'($urandom_range(0, 6000)) - 3000), 1'($urandom));
		idle_on = 1'b0;
		fork
			begin
				stall_long <= 1'b1;
				repeat (400) @(posedge clk);
				stall_long <= 1'b0;
			end
			for (i = 0; i < 40; i++)
				send_word(pick_sensors());
		join
		idle_on = 1'b1;
	endtask

	task automatic test_full_rate();
		int i;
		set_config(GAIN_W'($urandom), GAIN_W'($urandom),
			SETP_W'(int'($urandom_range(0, 6000)) - 3000), 1'($urandom));
		idle_on = 1'b0;
		for (i = 0; i < 150; i++)
			send_word(pick_sensors());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		raw_sensors = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_PROP_GAIN;
		cfg_data = '0;
		fail_count = 0;
		cycle_count = 0;
		stall_left = 0;
		stall_long = 1'b0;
		idle_on = 1'b1;
		steer_cfg.prop_gain = PROP_GAIN_RST;
		steer_cfg.deriv_gain = DERIV_GAIN_RST;
		steer_cfg.setpoint = SETPOINT_RST;
		steer_cfg.invert = INVERT_RST;
		held_error = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_cases();
		test_random_settings();
		test_output_backpressure();
		test_full_rate();

		drain_results();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
